@@ hdl/rrt_pkg.sv @@
package rrt_pkg;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  localparam int ENTRY_INDEX_BITS = 4;
  localparam int STATUS_BITS      = 2;
  localparam int OP_BITS          = 2;
  // byte offsets on the ports and in the stored ranges all use this width
  localparam int FIELD_BITS       = 48;
  localparam int COUNT_OUT_BITS   = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REC_RD,
    S_REC_CMP,
    S_POS_RD,
    S_POS_CMP,
    S_INSERT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WR_NEW,
    S_Q_FIRST_CMP,
    S_Q_RD,
    S_Q_CMP,
    S_RD_OUT,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic idx_zero;   // scan index := 0
    logic idx_inc;    // scan index += 1
    logic idx_top;    // scan index := count, insert position := scan index
    logic idx_dec;    // scan index -= 1
    logic rd_prev;    // read memory at scan index - 1
    logic rd_req;     // read memory at request entry index
    logic wr_merge;   // write merged range at scan index
    logic wr_shift;   // write read data at scan index
    logic wr_insert;  // write new range at scan index
    logic cnt_inc;
    logic cnt_clr;
    logic q_init;     // take reach from entry 0
    logic q_step;     // extend reach
    logic res_full;
    logic res_bad;
    logic res_query;
    logic res_query_pos;
    logic res_read;
    logic res_ok;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_end;    // scan index >= count
    logic       cnt_zero;
    logic       full;
    logic       hit;         // read entry overlaps/touches request
    logic       past_end;    // request end < entry start
    logic       q_stop;      // entry starts beyond reach and position
    logic       q_first_gt;  // entry 0 starts after position
    logic       idx_ok;      // request entry index < count
    logic       idx_at_pos;  // scan index == insert position
    op_t        op;
  } dp_status_t;

endpackage

@@ hdl/received_range_tracker.sv @@
// Range tracker: keeps up to MAX_RANGES sorted byte ranges in two small RAMs
// (starts and lengths) and handles one request at a time. A record scans for
// the first range it overlaps or touches and merges into it; if none does and
// the table is full the range is dropped, else it finds the insert point and
// shifts the tail up one entry from the top down before writing the new range.
// A query walks the entries from entry 0, a read fetches one entry and a clear
// empties the table. The scans go through one read address that both RAMs
// share, and the RAM read data is registered. The result is held until
// taken, and a new request is accepted in the cycle after that.
module received_range_tracker #(
  parameter int MAX_RANGES  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rrt_pkg::OP_BITS-1:0]          operation,
  input  logic [rrt_pkg::FIELD_BITS-1:0]       range_begin,
  input  logic [rrt_pkg::FIELD_BITS-1:0]       range_end,
  input  logic [rrt_pkg::ENTRY_INDEX_BITS-1:0] entry_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rrt_pkg::STATUS_BITS-1:0]      status,
  output logic [rrt_pkg::FIELD_BITS-1:0]       complete_end,
  output logic [rrt_pkg::FIELD_BITS-1:0]       entry_begin,
  output logic [rrt_pkg::FIELD_BITS-1:0]       entry_end,
  output logic [rrt_pkg::COUNT_OUT_BITS-1:0]   entry_count
);
  import rrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  rrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts));

  rrt_datapath #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .range_begin(range_begin), .range_end(range_end),
    .entry_index(entry_index), .status(status), .complete_end(complete_end),
    .entry_begin(entry_begin), .entry_end(entry_end), .entry_count(entry_count));

endmodule

@@ hdl/rrt_ram.sv @@
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/rrt_datapath.sv @@
module rrt_datapath #(
  parameter int MAX_RANGES  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rrt_pkg::dp_cmd_t                       cmd,
  output rrt_pkg::dp_status_t                    sts,
  input  logic [rrt_pkg::OP_BITS-1:0]            operation,
  input  logic [rrt_pkg::FIELD_BITS-1:0]         range_begin,
  input  logic [rrt_pkg::FIELD_BITS-1:0]         range_end,
  input  logic [rrt_pkg::ENTRY_INDEX_BITS-1:0]   entry_index,
  output logic [rrt_pkg::STATUS_BITS-1:0]        status,
  output logic [rrt_pkg::FIELD_BITS-1:0]         complete_end,
  output logic [rrt_pkg::FIELD_BITS-1:0]         entry_begin,
  output logic [rrt_pkg::FIELD_BITS-1:0]         entry_end,
  output logic [rrt_pkg::COUNT_OUT_BITS-1:0]     entry_count
);
  import rrt_pkg::*;

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = AW + 1;
  localparam int OW = FIELD_BITS;

  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [IW-1:0] ins_pos;
  op_t           op;
  logic [OW-1:0] rb, re, reach;
  logic [ENTRY_INDEX_BITS-1:0] req_idx;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [OW-1:0] ws, wl, rs, rl, rstop;
  logic [OW-1:0] nb, ne;

  rrt_ram #(.WIDTH(OW), .DEPTH(MAX_RANGES)) u_starts (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ws), .raddr(raddr), .rdata(rs));
  rrt_ram #(.WIDTH(OW), .DEPTH(MAX_RANGES)) u_lengths (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wl), .raddr(raddr), .rdata(rl));

  assign rstop = rs + rl;
  assign nb    = (rb < rs) ? rb : rs;
  assign ne    = (re > rstop) ? re : rstop;

  // request index may exceed the memory depth; the address is truncated
  always_comb begin
    if (cmd.rd_req) begin
      raddr = AW'(req_idx);
    end else if (cmd.rd_prev) begin
      raddr = AW'(idx - IW'(1));
    end else begin
      raddr = idx[AW-1:0];
    end
  end

  always_comb begin
    we    = cmd.wr_merge | cmd.wr_shift | cmd.wr_insert;
    waddr = idx[AW-1:0];
    ws    = rb;
    wl    = re - rb;
    if (cmd.wr_merge) begin
      ws = nb;
      wl = ne - nb;
    end else if (cmd.wr_shift) begin
      ws = rs;
      wl = rl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(operation);
      rb      <= range_begin;
      // reversed range collapses to an empty one
      re      <= (range_end < range_begin) ? range_begin : range_end;
      req_idx <= entry_index;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_top) begin
      idx <= IW'(count);
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
    if (cmd.idx_top) begin
      ins_pos <= idx;
    end
    if (cmd.q_init) begin
      reach <= rstop;
    end else if (cmd.q_step && rstop > reach) begin
      reach <= rstop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_full || cmd.res_bad || cmd.res_query || cmd.res_query_pos ||
        cmd.res_read || cmd.res_ok) begin
      status       <= ST_OK;
      complete_end <= '0;
      entry_begin  <= '0;
      entry_end    <= '0;
      if (cmd.res_full) status <= ST_FULL;
      if (cmd.res_bad) status <= ST_BAD_INDEX;
      if (cmd.res_query) complete_end <= reach;
      if (cmd.res_query_pos) complete_end <= rb;
      if (cmd.res_read) begin
        entry_begin <= rs;
        entry_end   <= rstop;
      end
    end
  end

  assign entry_count = COUNT_OUT_BITS'(count);

  always_comb begin
    sts.scan_end   = idx >= IW'(count);
    sts.cnt_zero   = count == '0;
    sts.full       = count >= CW'(MAX_RANGES);
    sts.hit        = (rb >= rs && rb <= rstop) || (re >= rs && re <= rstop) ||
                     (rb < rs && re > rstop);
    sts.past_end   = re < rs;
    sts.q_stop     = rs > reach && rs > rb;
    sts.q_first_gt = rs > rb;
    sts.idx_ok     = 32'(req_idx) < 32'(count);
    sts.idx_at_pos = idx == ins_pos;
    sts.op         = op;
  end

endmodule

@@ hdl/rrt_ctrl.sv @@
module rrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rrt_pkg::dp_cmd_t    cmd,
  input  rrt_pkg::dp_status_t sts
);
  import rrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.idx_zero = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // idx is 0, so entry 0 is read here for a query
        unique case (sts.op)
          OP_RECORD: state_next = S_REC_RD;
          OP_QUERY: begin
            if (sts.cnt_zero) begin
              cmd.res_query_pos = 1'b1;
              state_next        = S_DONE;
            end else begin
              state_next = S_Q_FIRST_CMP;
            end
          end
          OP_READ: begin
            cmd.rd_req = 1'b1;
            if (sts.idx_ok) begin
              state_next = S_RD_OUT;
            end else begin
              cmd.res_bad = 1'b1;
              state_next  = S_DONE;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_ok  = 1'b1;
            state_next  = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_REC_RD: begin
        if (sts.scan_end) begin
          if (sts.full) begin
            cmd.res_full = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.idx_zero = 1'b1;
            state_next   = S_POS_RD;
          end
        end else begin
          state_next = S_REC_CMP;
        end
      end
      S_REC_CMP: begin
        if (sts.hit) begin
          cmd.wr_merge = 1'b1;
          cmd.res_ok   = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_REC_RD;
        end
      end
      S_POS_RD: begin
        if (sts.scan_end) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_POS_CMP;
        end
      end
      S_POS_CMP: begin
        if (sts.past_end) begin
          state_next = S_INSERT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_POS_RD;
        end
      end
      S_INSERT: begin
        // latch position, then move entries up one slot from the top down
        cmd.idx_top = 1'b1;
        state_next  = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (sts.idx_at_pos) begin
          state_next = S_WR_NEW;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_WR_NEW: begin
        cmd.wr_insert = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.res_ok    = 1'b1;
        state_next    = S_DONE;
      end
      S_Q_FIRST_CMP: begin
        if (sts.q_first_gt) begin
          cmd.res_query_pos = 1'b1;
          state_next        = S_DONE;
        end else begin
          cmd.q_init  = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_Q_RD;
        end
      end
      S_Q_RD: begin
        if (sts.scan_end) begin
          cmd.res_query = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        if (sts.q_stop) begin
          cmd.res_query = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.q_step  = 1'b1;
          cmd.idx_inc = 1'b1;
          state_next  = S_Q_RD;
        end
      end
      S_RD_OUT: begin
        cmd.res_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ tb/received_range_tracker_checker.sv @@
module received_range_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [47:0] range_begin,
  input  logic [47:0] range_end,
  input  logic [3:0]  entry_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [47:0] complete_end,
  input  logic [47:0] entry_begin,
  input  logic [47:0] entry_end,
  input  logic [4:0]  entry_count,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrt_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    status_t     st;
    logic [47:0] cend;
    logic [47:0] eb;
    logic [47:0] ee;
    logic [4:0]  cnt;
  } reply_t;

  logic [47:0] lo_tab [DEPTH];
  logic [47:0] len_tab [DEPTH];
  int          used;
  reply_t      expected_replies[$];

  assign pending = expected_replies.size();

  function automatic logic [47:0] stop_of(int k);
    return lo_tab[k] + len_tab[k];
  endfunction

  function automatic status_t merge_range(logic [47:0] b, logic [47:0] e);
    logic [47:0] b1, e1, nb, ne;
    int pos;
    if (e < b) e = b;
    for (int k = 0; k < used; k++) begin
      b1 = lo_tab[k];
      e1 = stop_of(k);
      if ((b >= b1 && b <= e1) || (e >= b1 && e <= e1) || (b < b1 && e > e1)) begin
        nb = (b < b1) ? b : b1;
        ne = (e > e1) ? e : e1;
        lo_tab[k] = nb;
        len_tab[k] = ne - nb;
        return ST_OK;
      end
    end
    if (used >= DEPTH) return ST_FULL;
    pos = 0;
    while (pos < used && !(e < lo_tab[pos])) pos++;
    for (int k = used; k > pos; k--) begin
      lo_tab[k] = lo_tab[k-1];
      len_tab[k] = len_tab[k-1];
    end
    lo_tab[pos] = b;
    len_tab[pos] = e - b;
    used++;
    return ST_OK;
  endfunction

  function automatic logic [47:0] coverage_end(logic [47:0] p);
    logic [47:0] reach, s;
    if (used == 0 || lo_tab[0] > p) return p;
    reach = stop_of(0);
    for (int k = 1; k < used; k++) begin
      s = lo_tab[k];
      if (s > reach && s > p) break;
      if (stop_of(k) > reach) reach = stop_of(k);
    end
    return reach;
  endfunction

  function automatic reply_t predict(op_t op, logic [47:0] b, logic [47:0] e, logic [3:0] idx);
    reply_t r;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_RECORD: r.st = merge_range(b, e);
      OP_QUERY:  r.cend = coverage_end(b);
      OP_READ: begin
        if (idx < used) begin
          r.eb = lo_tab[idx];
          r.ee = stop_of(idx);
        end else begin
          r.st = ST_BAD_INDEX;
        end
      end
      default: used = 0;
    endcase
    r.cnt = used[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t x, r;
    if (rst) begin
      used = 0;
      fail_count <= 0;
      expected_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        r = predict(op_t'(operation), range_begin, range_end, entry_index);
        expected_replies = {expected_replies, r};
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got status %0d", $time, status);
          fail_count <= fail_count + 1;
        end else begin
          x = expected_replies.pop_front();
          if (status !== x.st || complete_end !== x.cend || entry_begin !== x.eb ||
              entry_end !== x.ee || entry_count !== x.cnt) begin
            $display("%0t: mismatch expected st=%0d cend=%h eb=%h ee=%h cnt=%0d",
                     $time, x.st, x.cend, x.eb, x.ee, x.cnt);
            $display("%0t:          actual   st=%0d cend=%h eb=%h ee=%h cnt=%0d",
                     $time, status, complete_end, entry_begin, entry_end, entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_received_range_tracker.sv @@
module tb_received_range_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import rrt_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [47:0] range_begin = '0;
  logic [47:0] range_end = '0;
  logic [3:0]  entry_index = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [47:0] complete_end, entry_begin, entry_end;
  logic [4:0]  entry_count;
  int          fail_count, pending;
  bit          sending_done = 0;
  logic [47:0] base_ofs;

  always #4 clk = ~clk;

  received_range_tracker DUT (.*);
  received_range_tracker_checker u_checker (.*);

  task automatic send_request(op_t op, logic [47:0] b, logic [47:0] e, logic [3:0] idx);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    range_begin <= b;
    range_end <= e;
    entry_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // receiver: random stall per reply, sometimes long runs of always-ready
  initial begin
    int burst, gap;
    @(negedge rst);
    forever begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : 0;
      if (burst > 0) begin
        out_ready <= 1;
        repeat (burst) @(posedge clk);
      end else begin
        gap = $urandom_range(0, 17);
        if (gap > 0) begin
          out_ready <= 0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  initial begin
    logic [47:0] b, e;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty list, extremes, reversed and empty ranges, gaps, full table
    send_request(OP_QUERY, 48'h1234, 0, 0);
    send_request(OP_READ, 0, 0, 0);
    send_request(OP_RECORD, 48'd100, 48'd200, 0);
    send_request(OP_RECORD, 48'd300, 48'd250, 0);
    send_request(OP_RECORD, 48'd200, 48'd200, 0);
    send_request(OP_RECORD, 48'd10, 48'd20, 0);
    send_request(OP_RECORD, '1, '1, 0);
    send_request(OP_QUERY, 48'd150, 0, 0);
    send_request(OP_QUERY, 48'd5, 0, 0);
    send_request(OP_QUERY, 48'd250, 0, 0);
    send_request(OP_READ, 0, 0, 4'd1);
    send_request(OP_READ, 0, 0, 4'd15);
    for (int i = 0; i < 16; i++)
      send_request(OP_RECORD, 48'd1000 * 48'(i + 2), 48'd1000 * 48'(i + 2) + 48'd10, 0);
    send_request(OP_RECORD, 48'h7fff_0000_0000, 48'h7fff_0000_0010, 0);
    send_request(OP_READ, 0, 0, 4'd15);
    send_request(OP_CLEAR, '1, '1, '1);
    send_request(OP_RECORD, 0, '1, 0);
    send_request(OP_CLEAR, 0, 0, 0);
    // random: mostly clustered offsets so ranges touch, overlap and fill up
    for (int n = 0; n < 1000; n++) begin
      if (n % 60 == 0) base_ofs = ($urandom_range(0, 3) == 0) ? rand48() : '0;
      if ($urandom_range(0, 9) == 0) begin
        b = rand48();
        e = rand48();
      end else begin
        b = base_ofs + 48'($urandom_range(0, 400));
        e = b + 48'($urandom_range(0, 30)) -
            48'(($urandom_range(0, 15) == 0) ? 40 : 0);
      end
      case ($urandom_range(0, 19))
        0:                 send_request(OP_CLEAR, b, e, 4'($urandom()));
        1, 2, 3, 4:        send_request(OP_QUERY, b, e, 4'($urandom()));
        5, 6, 7:           send_request(OP_READ, b, e, 4'($urandom()));
        default:           send_request(OP_RECORD, b, e, 4'($urandom()));
      endcase
    end
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("[received_range_tracker] OK");
    else
      $display("[received_range_tracker] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[received_range_tracker] ERROR");
    $finish;
  end
endmodule
